/* rtl/core/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character codes and small helper functions for the
// integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 8;
  // Dividend bits retired per divider cycle
  localparam int DIV_BITS = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture a new number
    logic push_zero;   // push a single zero digit
    logic shift_step;  // power-of-two base: one digit by mask and shift
    logic div_start;   // start the divider on the current quotient
    logic div_push;    // push divider remainder, take its quotient
    logic emit_minus;  // load '-' into the output register
    logic pop;         // pop the top digit into the read register
    logic emit_digit;  // load the popped digit's glyph into the output register
  } itoa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic q_zero;
    logic cnt_zero;
    logic pow2;
    logic minus;
    logic div_done;
    logic out_free;
  } itoa_sts_t;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) res = CHAR_ZERO + CHAR_W'(d);
    else           res = CHAR_UPPER + CHAR_W'(d - 4'd10);
    return res;
  endfunction

  // Shift amount for a power-of-two base, zero for any other base
  function automatic logic [2:0] pow2_shift(input logic [RADIX_W-1:0] r);
    logic [2:0] res;
    case (r)
      5'd2:    res = 3'd1;
      5'd4:    res = 3'd2;
      5'd8:    res = 3'd3;
      5'd16:   res = 3'd4;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/core/itoa_div.sv */
// ----------------------------------------------------------------------------
// itoa_div
// Restoring divider of a wide dividend by a base of 2 to 16, retiring
// DIV_BITS dividend bits per cycle; done pulses when the result is ready.
// ----------------------------------------------------------------------------
module itoa_div
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [DIGIT_W-1:0]    remainder
);

  localparam int DIV_W   = ((VALUE_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int STEPS   = DIV_W / DIV_BITS;
  localparam int STEP_CW = $clog2(STEPS + 1);

  logic [DIV_W-1:0]   acc;
  logic [DIGIT_W-1:0] rem;
  logic [STEP_CW-1:0] cnt;
  logic               busy;
  logic [DIV_W-1:0]   acc_next;
  logic [DIGIT_W-1:0] rem_next;

  // Quotient bits enter at the bottom as dividend bits leave at the top
  always_comb begin
    logic [RADIX_W-1:0] t;
    acc_next = acc;
    rem_next = rem;
    for (int i = 0; i < DIV_BITS; i++) begin
      t        = {rem_next, acc_next[DIV_W-1]};
      acc_next = {acc_next[DIV_W-2:0], 1'b0};
      if (t >= divisor) begin
        rem_next    = DIGIT_W'(t - divisor);
        acc_next[0] = 1'b1;
      end else begin
        rem_next = t[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= STEP_CW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - STEP_CW'(1);
        if (cnt == STEP_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= DIV_W'(dividend);
      rem <= '0;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient  = acc[VALUE_BITS-1:0];
  assign remainder = rem;

endmodule

/* rtl/core/itoa_dp.sv */
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: quotient and base registers, digit stack, divider and the
// output register of the character stream.
// ----------------------------------------------------------------------------
module itoa_dp
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  itoa_cmd_t             cmd,
  output itoa_sts_t             sts,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_W-1:0]    radix,
  input  logic                  signed_mode,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [CHAR_W-1:0]     text_char,
  output logic                  last_char
);

  localparam int CW = $clog2(VALUE_BITS + 1);
  localparam int AW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quotient;
  logic [RADIX_W-1:0]    base;
  logic [2:0]            shamt;
  logic [CW-1:0]         count;
  logic                  minus;
  logic [DIGIT_W-1:0]    stack_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]    rd_digit;

  logic [RADIX_W-1:0]    eff_radix;
  logic                  negate;
  logic [DIGIT_W-1:0]    pow_digit;
  logic                  push_en;
  logic [DIGIT_W-1:0]    push_digit;
  logic [CW-1:0]         count_dec;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  assign eff_radix = sat_radix(radix);
  assign negate    = signed_mode && (eff_radix == RADIX_DEC) && value[VALUE_BITS-1];
  assign pow_digit = quotient[DIGIT_W-1:0] & (base[DIGIT_W-1:0] - 4'd1);
  assign push_en   = cmd.push_zero | cmd.shift_step | cmd.div_push;
  assign count_dec = count - CW'(1);

  always_comb begin
    push_digit = '0;
    if (cmd.shift_step)    push_digit = pow_digit;
    else if (cmd.div_push) push_digit = div_rem;
  end

  itoa_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (quotient),
    .divisor   (base),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      minus    <= 1'b0;
      quotient <= '0;
    end else begin
      if (cmd.load) begin
        count    <= '0;
        minus    <= negate;
        quotient <= negate ? ({VALUE_BITS{1'b0}} - value) : value;
      end else begin
        if (push_en)        count <= count + CW'(1);
        else if (cmd.pop)   count <= count_dec;
        if (cmd.shift_step) quotient <= quotient >> shamt;
        else if (cmd.div_push) quotient <= div_quot;
        if (cmd.emit_minus) minus <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base  <= eff_radix;
      shamt <= pow2_shift(eff_radix);
    end
  end

  // Digit stack
  always_ff @(posedge clk) begin
    if (push_en) stack_mem[count[AW-1:0]] <= push_digit;
    if (cmd.pop) rd_digit <= stack_mem[count_dec[AW-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_minus || cmd.emit_digit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_minus) begin
      text_char <= CHAR_MINUS;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      text_char <= digit_glyph(rd_digit);
      last_char <= (count == '0);
    end
  end

  always_comb begin
    sts.q_zero   = (quotient == '0);
    sts.cnt_zero = (count == '0);
    sts.pow2     = (shamt != 3'd0);
    sts.minus    = minus;
    sts.div_done = div_done;
    sts.out_free = !m_tvalid || m_tready;
  end

endmodule

/* rtl/core/itoa_ctrl.sv */
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences load, digit extraction, sign and digit emission.
// ----------------------------------------------------------------------------
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  itoa_sts_t sts,
  output itoa_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SIGN,
    S_READ,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.q_zero) begin
          // zero still needs one digit
          if (sts.cnt_zero) cmd.push_zero = 1'b1;
          else              state_next = S_SIGN;
        end else if (sts.pow2) begin
          cmd.shift_step = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_push = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_SIGN: begin
        if (!sts.minus) begin
          state_next = S_READ;
        end else if (sts.out_free) begin
          cmd.emit_minus = 1'b1;
          state_next     = S_READ;
        end
      end
      S_READ: begin
        cmd.pop    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          state_next     = sts.cnt_zero ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/integer_to_ascii_radix.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a number to its ASCII digits in a base of 2 to 16.
// ----------------------------------------------------------------------------
// One number enters per transfer on the slave side and leaves as a stream of
// characters, most significant digit first, the final one marked by tlast.
// Bases below 2 or above 16 saturate; signed mode applies in base ten only
// and prefixes '-'. The block works on one number at a time: a load cycle,
// then digits by mask and shift in a power-of-two base or by the divider in
// any other base, which retires four dividend bits a cycle while busy; then a
// check that closes the digit loop and a sign step that also emits any minus,
// then a digit stack read and an output register load for each digit
// character. A stall on m_tready holds the sign and emit cycles for as long
// as it lasts.
// The next number is taken while the last character still waits on m_tready.
module integer_to_ascii_radix
  import itoa_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // value, radix, signed_mode from bit 0 up; zero padded to whole bytes
  input  logic [((VALUE_BITS + RADIX_W + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // text_char
  output logic [CHAR_W-1:0]   m_tdata,
  output logic                m_tlast
);

  localparam int RADIX_LSB = VALUE_BITS;
  localparam int SIGN_POS  = VALUE_BITS + RADIX_W;

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .value       (s_tdata[VALUE_BITS-1:0]),
    .radix       (s_tdata[RADIX_LSB +: RADIX_W]),
    .signed_mode (s_tdata[SIGN_POS]),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .text_char   (m_tdata),
    .last_char   (m_tlast)
  );

  // One number at a time: no second transfer straight after an accepted one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a number is in progress");

  // A character that is not the last means more digits are still owed
  a_busy_mid_number: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("ready for input in the middle of a number");

  // The sign always precedes at least one digit
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == CHAR_MINUS) |-> !m_tlast)
    else $error("minus sign marked as last character");

  // A finished character waits for the sink
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output character dropped or changed while stalled");

endmodule
